>>> rtl/core/rtcm3_pkg.sv
// shared types, constants and the crc-24q byte step for the rtcm3 frame checker
// depends on nothing; used by rtcm3_fc_front, rtcm3_fc_queue and the top level
package rtcm3_pkg;

    localparam logic [7:0]  PREAMBLE  = 8'd211;
    localparam logic [23:0] CRC_POLY  = 24'h864CFB;
    localparam logic [10:0] MIN_BYTES = 11'd7;
    localparam logic [10:0] HDR_BYTES = 11'd3;
    localparam logic [10:0] HDR_PAR   = 11'd6;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RECV,
        PH_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        V_PASS,
        V_BAD_PREAMBLE,
        V_TOO_SHORT,
        V_CRC_MISMATCH,
        V_TYPE_ZERO
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [11:0] message_type;
        logic [10:0] frame_bytes;
        logic [9:0]  payload_length;
        logic [23:0] computed_crc;
    } t_result;

    // msb-first crc-24q over one byte, eight shift steps
    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {b, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            if (c[23]) begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [23:0] CRC_AFTER_PRE = crc_byte(24'h000000, PREAMBLE);

    // verdict once the whole frame is in
    function automatic t_result make_final(input logic [23:0] crc, input logic [23:0] par,
                                           input logic [11:0] typ, input logic [9:0] plen);
        t_result r;
        r.payload_length = plen;
        r.computed_crc   = crc;
        if (crc != par) begin
            r.verdict      = V_CRC_MISMATCH;
            r.message_type = typ;
            r.frame_bytes  = 11'd0;
        end else if (typ == 12'd0) begin
            r.verdict      = V_TYPE_ZERO;
            r.message_type = 12'd0;
            r.frame_bytes  = {1'b0, plen} + HDR_PAR;
        end else begin
            r.verdict      = V_PASS;
            r.message_type = typ;
            r.frame_bytes  = {1'b0, plen} + HDR_PAR;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rtcm3_frame_checker_unit.sv
// top level of the rtcm3 frame checker: byte stream in, one verdict per buffer out
// depends on rtcm3_pkg, rtcm3_fc_front and rtcm3_fc_queue
//
// usage
//   slave channel: one received byte per transfer; tuser marks the first byte
//   of a buffer (restarts checking), tlast marks the last byte available
//   master channel: one verdict transfer per buffer (bad preamble, too short,
//   crc mismatch, type zero or pass) with type, size, length and crc-24q
//   verdicts: a verdict is written into the queue on the byte that decides it
//   and is offered on the master side once the verdicts before it are taken
//   throughput: one byte per cycle while the queue is not full; the crc-24q
//   byte step and the frame tracker finish within the cycle the byte is taken
//   stalls: a four-entry verdict queue sits between the front part and the
//   master port; tready on the slave side only drops while that queue is full
//   reset: synchronous, active low; the tracker goes idle and the queue empties,
//   bytes before the first start mark are dropped
module rtcm3_frame_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] frame_start
    input  logic        i_s_tlast,   // buffer_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] verdict, [14:3] message_type, [25:15] frame_bytes,
    // [35:26] payload_length, [59:36] computed_crc, [63:60] zero
    output logic [63:0] o_m_tdata
);

    logic               s_xfer;
    logic               front_emit;
    rtcm3_pkg::t_result front_res;
    rtcm3_pkg::t_result head_res;
    logic               q_full;

    // a byte is taken whenever the queue has room for a possible verdict
    assign o_s_tready = !q_full;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    rtcm3_fc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_xfer),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser),
        .i_last   (i_s_tlast),
        .o_emit   (front_emit),
        .o_result (front_res)
    );

    rtcm3_fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_emit),
        .i_data  (front_res),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_full  (q_full),
        .o_data  (head_res)
    );

    // pack the verdict fields, first field in the low bits
    assign o_m_tdata = {4'h0,
                        head_res.computed_crc,
                        head_res.payload_length,
                        head_res.frame_bytes,
                        head_res.message_type,
                        head_res.verdict};

endmodule

>>> rtl/core/rtcm3_fc_front.sv
// front part: takes bytes, tracks the frame, runs crc-24q and forms verdicts
// depends on rtcm3_pkg
module rtcm3_fc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_start,
    input  logic               i_last,
    output logic               o_emit,
    output rtcm3_pkg::t_result o_result
);

    rtcm3_pkg::t_phase r_phase, n_phase;
    logic [10:0] r_count, n_count;
    logic [9:0]  r_plen, n_plen;
    logic [23:0] r_crc, n_crc;
    logic [23:0] r_par, n_par;
    logic [11:0] r_type, n_type;

    logic [9:0]  plen_new;
    logic [10:0] count_new;
    logic        in_crc;
    logic [23:0] crc_new;
    logic [23:0] par_new;
    logic [11:0] type_new;
    logic        at_end;
    rtcm3_pkg::t_result short_res;

    // header length field, overwritten on byte one and merged on byte two
    always_comb begin
        if (r_count == 11'd1) begin
            plen_new = {i_byte[1:0], 8'h00};
        end else if (r_count == 11'd2) begin
            plen_new = r_plen | {2'b00, i_byte};
        end else begin
            plen_new = r_plen;
        end
    end

    assign count_new = r_count + 11'd1;
    assign in_crc    = r_count < ({1'b0, plen_new} + rtcm3_pkg::HDR_BYTES);
    assign crc_new   = in_crc ? rtcm3_pkg::crc_byte(r_crc, i_byte) : r_crc;
    assign par_new   = in_crc ? r_par : {r_par[15:0], i_byte};
    assign at_end    = (r_count >= 11'd2) && (count_new == ({1'b0, plen_new} + rtcm3_pkg::HDR_PAR));

    always_comb begin
        if (r_count == 11'd3) begin
            type_new = {i_byte, 4'h0};
        end else if (r_count == 11'd4) begin
            type_new = r_type | {8'h00, i_byte[7:4]};
        end else begin
            type_new = r_type;
        end
    end

    always_comb begin
        short_res                = '0;
        short_res.verdict        = rtcm3_pkg::V_TOO_SHORT;
        short_res.payload_length = (count_new >= 11'd3) ? plen_new : 10'd0;
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_plen   = r_plen;
        n_crc    = r_crc;
        n_par    = r_par;
        n_type   = r_type;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_valid) begin
            if (i_start) begin
                n_phase = rtcm3_pkg::PH_IDLE;
                n_count = 11'd0;
                n_plen  = 10'd0;
                n_crc   = 24'h000000;
                n_par   = 24'h000000;
                n_type  = 12'd0;
                if (i_byte != rtcm3_pkg::PREAMBLE) begin
                    o_emit           = 1'b1;
                    o_result.verdict = rtcm3_pkg::V_BAD_PREAMBLE;
                end else begin
                    n_crc   = rtcm3_pkg::CRC_AFTER_PRE;
                    n_count = 11'd1;
                    if (i_last) begin
                        o_emit           = 1'b1;
                        o_result.verdict = rtcm3_pkg::V_TOO_SHORT;
                    end else begin
                        n_phase = rtcm3_pkg::PH_RECV;
                    end
                end
            end else begin
                case (r_phase)
                    rtcm3_pkg::PH_WAIT: begin
                        o_emit   = 1'b1;
                        o_result = rtcm3_pkg::make_final(r_crc, r_par, r_type, r_plen);
                        n_phase  = rtcm3_pkg::PH_IDLE;
                    end
                    rtcm3_pkg::PH_RECV: begin
                        n_count = count_new;
                        n_plen  = plen_new;
                        n_crc   = crc_new;
                        n_par   = par_new;
                        n_type  = type_new;
                        if (at_end && (count_new >= rtcm3_pkg::MIN_BYTES)) begin
                            o_emit   = 1'b1;
                            o_result = rtcm3_pkg::make_final(crc_new, par_new, type_new,
                                                             plen_new);
                            n_phase  = rtcm3_pkg::PH_IDLE;
                        end else if (i_last) begin
                            o_emit   = 1'b1;
                            o_result = short_res;
                            n_phase  = rtcm3_pkg::PH_IDLE;
                        end else if (at_end) begin
                            // zero-length frame, verdict held for a seventh byte
                            n_phase = rtcm3_pkg::PH_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtcm3_pkg::PH_IDLE;
            r_count <= 11'd0;
            r_plen  <= 10'd0;
            r_crc   <= 24'h000000;
            r_par   <= 24'h000000;
            r_type  <= 12'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_plen  <= n_plen;
            r_crc   <= n_crc;
            r_par   <= n_par;
            r_type  <= n_type;
        end
    end

`ifndef ASSERT_OFF
    a_pass_has_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.verdict == rtcm3_pkg::V_PASS) |->
        (o_result.message_type != 12'd0 && o_result.frame_bytes >= rtcm3_pkg::HDR_PAR))
        else $error("pass verdict with zero type or bad size");
    a_bad_pre_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.verdict == rtcm3_pkg::V_BAD_PREAMBLE) |->
        (o_result.frame_bytes == 11'd0 && o_result.computed_crc == 24'h000000
         && o_result.payload_length == 10'd0))
        else $error("bad preamble verdict carries fields");
    a_start_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_start && i_byte == rtcm3_pkg::PREAMBLE && !i_last) |=>
        (r_phase == rtcm3_pkg::PH_RECV && r_count == 11'd1))
        else $error("good start byte did not open a frame");
`endif

endmodule

>>> rtl/core/rtcm3_fc_queue.sv
// short verdict queue between the front part and the output channel
// depends on rtcm3_pkg
module rtcm3_fc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rtcm3_pkg::t_result i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output rtcm3_pkg::t_result o_data
);

    rtcm3_pkg::t_result r_mem [rtcm3_pkg::Q_DEPTH];
    logic [rtcm3_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rtcm3_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rtcm3_pkg::Q_CNT_W-1:0] r_count, n_count;
    logic do_push;
    logic do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == rtcm3_pkg::Q_CNT_W'(rtcm3_pkg::Q_DEPTH);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("verdict pushed into a full queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not rise on push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule
